@@ design/gbnsw_pkg.sv @@
package gbnsw_pkg;

  // Sequence numbers wrap over a space of this many values.
  localparam int SeqSpace  = 32;
  localparam int SeqW      = $clog2(SeqSpace);
  // Most packets resent by one timeout, and the ceiling of the window.
  localparam int MaxWindow = 16;

  localparam int LenW      = 7;
  localparam int WinW      = 5;
  localparam int OpW       = 2;
  localparam int KindW     = 3;

  // Register file of the configuration port.
  localparam int AddrW     = 3;
  localparam int DataW     = 32;
  localparam logic [AddrW-1:0] AddrWindowSize = 3'd0;
  localparam logic [WinW-1:0]  WindowSizeRst  = 5'd8;

  // Input operation codes.
  localparam logic [OpW-1:0] OpData    = 2'd0;
  localparam logic [OpW-1:0] OpAck     = 2'd1;
  localparam logic [OpW-1:0] OpTimeout = 2'd2;
  localparam logic [OpW-1:0] OpEnd     = 2'd3;

  // Result kinds.
  localparam logic [KindW-1:0] KindSent     = 3'd0;
  localparam logic [KindW-1:0] KindResent   = 3'd1;
  localparam logic [KindW-1:0] KindAckTaken = 3'd2;
  localparam logic [KindW-1:0] KindAckIgn   = 3'd3;
  localparam logic [KindW-1:0] KindFull     = 3'd4;
  localparam logic [KindW-1:0] KindNone     = 3'd5;
  localparam logic [KindW-1:0] KindEnd      = 3'd6;

  typedef struct packed {
    logic [OpW-1:0]  opcode;
    logic [SeqW-1:0] ack_number;
    logic [LenW-1:0] data_length;
  } in_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [SeqW-1:0]  sequence_res;
    logic [LenW-1:0]  length;
    logic             restart_timer;
    logic             all_done;
    logic             last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_step;     // Accept an item and load its single result.
    logic start_resend;  // Accept a timeout and arm the resend walk.
    logic load_resend;   // Load the next resend result.
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic resend_req;    // Current input is a timeout with packets outstanding.
    logic resend_fin;    // The resend being loaded is the final one.
  } ctrl_sts_t;

endpackage

@@ design/gbnsw_ctrl.sv @@
module gbnsw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  gbnsw_pkg::ctrl_sts_t  sts_i,
  output gbnsw_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StSend = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  // The output register can take a new result when empty or being drained.
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle) && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Sequencer for single results and for the timeout resend walk.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (sts_i.resend_req) begin
            cmd_o.start_resend = 1'b1;
            state_d            = StRead;
          end else begin
            cmd_o.load_step = 1'b1;
          end
        end
      end
      StRead: begin
        // The length store read is registered; its data is ready next cycle.
        state_d = StSend;
      end
      StSend: begin
        if (out_free) begin
          cmd_o.load_resend = 1'b1;
          state_d           = sts_i.resend_fin ? StIdle : StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output valid is set on every load and cleared once the transfer completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_step || cmd_o.load_resend) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ design/gbnsw_datapath.sv @@
module gbnsw_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [gbnsw_pkg::WinW-1:0]      window_size_i,
  input  gbnsw_pkg::in_t                  in_data_i,
  output gbnsw_pkg::out_t                 out_data_o,
  input  gbnsw_pkg::ctrl_cmd_t            cmd_i,
  output gbnsw_pkg::ctrl_sts_t            sts_o
);

  localparam int SeqW = gbnsw_pkg::SeqW;
  localparam int LenW = gbnsw_pkg::LenW;
  localparam int WinW = gbnsw_pkg::WinW;

  logic [SeqW-1:0] base_q, base_d;
  logic [SeqW-1:0] next_seq_q, next_seq_d;
  logic            end_seen_q, end_seen_d;
  logic [SeqW-1:0] resend_cnt_q, resend_cnt_d;
  logic [SeqW-1:0] resend_num_q, resend_num_d;
  gbnsw_pkg::out_t out_q, out_d;
  gbnsw_pkg::out_t step_res;

  // Length store, indexed by sequence number, with a registered read port.
  logic [LenW-1:0] len_mem [gbnsw_pkg::SeqSpace];
  logic [LenW-1:0] rd_len_q;
  logic            mem_we;
  logic [SeqW-1:0] rd_addr;

  logic [SeqW-1:0] outs;
  logic [WinW-1:0] eff_win;
  logic            full;
  logic [SeqW-1:0] ack_off;
  logic [SeqW-1:0] ack_base;
  logic            ack_taken;

  // Outstanding count and the effective window, clamped to one and the ceiling.
  assign outs    = next_seq_q - base_q;
  always_comb begin
    eff_win = window_size_i;
    if (window_size_i == '0) begin
      eff_win = WinW'(1);
    end else if (window_size_i > WinW'(gbnsw_pkg::MaxWindow)) begin
      eff_win = WinW'(gbnsw_pkg::MaxWindow);
    end
  end
  assign full      = {{(WinW > SeqW ? 0 : SeqW - WinW){1'b0}}, outs} >= eff_win;
  assign ack_off   = in_data_i.ack_number - base_q;
  assign ack_base  = in_data_i.ack_number + SeqW'(1);
  assign ack_taken = ack_off < outs;

  assign sts_o.resend_req = (in_data_i.opcode == gbnsw_pkg::OpTimeout) && (outs != '0);
  assign sts_o.resend_fin = (resend_cnt_q == resend_num_q - SeqW'(1));

  // Result of an item that causes exactly one result.
  always_comb begin
    step_res               = '0;
    step_res.last          = 1'b1;
    step_res.sequence_res  = base_q;
    case (in_data_i.opcode)
      gbnsw_pkg::OpData: begin
        if (full) begin
          step_res.kind = gbnsw_pkg::KindFull;
        end else begin
          step_res.kind          = gbnsw_pkg::KindSent;
          step_res.sequence_res  = next_seq_q;
          step_res.length        = in_data_i.data_length;
          step_res.restart_timer = (outs == '0);
        end
      end
      gbnsw_pkg::OpAck: begin
        if (ack_taken) begin
          step_res.kind          = gbnsw_pkg::KindAckTaken;
          step_res.sequence_res  = ack_base;
          step_res.restart_timer = 1'b1;
          step_res.all_done      = end_seen_q && (ack_base == next_seq_q);
        end else begin
          step_res.kind     = gbnsw_pkg::KindAckIgn;
          step_res.all_done = end_seen_q && (outs == '0);
        end
      end
      gbnsw_pkg::OpTimeout: begin
        // Only reached with nothing outstanding.
        step_res.kind     = gbnsw_pkg::KindNone;
        step_res.all_done = end_seen_q;
      end
      default: begin
        step_res.kind     = gbnsw_pkg::KindEnd;
        step_res.all_done = (outs == '0);
      end
    endcase
  end

  assign mem_we = cmd_i.load_step && (in_data_i.opcode == gbnsw_pkg::OpData) && !full;

  // Window state updates.
  always_comb begin
    base_d       = base_q;
    next_seq_d   = next_seq_q;
    end_seen_d   = end_seen_q;
    resend_cnt_d = resend_cnt_q;
    resend_num_d = resend_num_q;
    if (cmd_i.load_step) begin
      if (mem_we) begin
        next_seq_d = next_seq_q + SeqW'(1);
      end
      if ((in_data_i.opcode == gbnsw_pkg::OpAck) && ack_taken) begin
        base_d = ack_base;
      end
      if (in_data_i.opcode == gbnsw_pkg::OpEnd) begin
        end_seen_d = 1'b1;
      end
    end
    if (cmd_i.start_resend) begin
      resend_cnt_d = '0;
      resend_num_d = (outs > SeqW'(gbnsw_pkg::MaxWindow)) ?
                     SeqW'(gbnsw_pkg::MaxWindow) : outs;
    end
    if (cmd_i.load_resend) begin
      resend_cnt_d = resend_cnt_q + SeqW'(1);
    end
  end

  // Output register payload.
  assign rd_addr = base_q + resend_cnt_q;
  always_comb begin
    out_d = out_q;
    if (cmd_i.load_step) begin
      out_d = step_res;
    end else if (cmd_i.load_resend) begin
      out_d.kind          = gbnsw_pkg::KindResent;
      out_d.sequence_res  = rd_addr;
      out_d.length        = rd_len_q;
      out_d.restart_timer = sts_o.resend_fin;
      out_d.all_done      = 1'b0;
      out_d.last          = sts_o.resend_fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      next_seq_q   <= '0;
      end_seen_q   <= 1'b0;
      resend_cnt_q <= '0;
      resend_num_q <= '0;
    end else begin
      base_q       <= base_d;
      next_seq_q   <= next_seq_d;
      end_seen_q   <= end_seen_d;
      resend_cnt_q <= resend_cnt_d;
      resend_num_q <= resend_num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Length store write on a send, read of the next resend slot every cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      len_mem[next_seq_q] <= in_data_i.data_length;
    end
    rd_len_q <= len_mem[rd_addr];
  end

  assign out_data_o = out_q;

endmodule

@@ design/go_back_n_sender_window_unit.sv @@
// Data, ack, end, idle timeout items: one result, shown the cycle after the transfer.
// Such items are taken back to back, one per cycle, while the output can drain.
// A timeout with k packets outstanding gives k resends, paced by the registered read
// of the length store; no item is taken until the last is loaded.
// Reset clears the window base, next sequence and end flag, sets window_size to 8,
// and leaves the length store unwritten.
module go_back_n_sender_window_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  gbnsw_pkg::in_t                    in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output gbnsw_pkg::out_t                   out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gbnsw_pkg::AddrW-1:0]       paddr,
  input  logic [gbnsw_pkg::DataW-1:0]       pwdata,
  output logic [gbnsw_pkg::DataW-1:0]       prdata,
  output logic                              pready
);

  logic [gbnsw_pkg::WinW-1:0] window_size_q;
  logic                       win_sel;
  gbnsw_pkg::ctrl_cmd_t       cmd;
  gbnsw_pkg::ctrl_sts_t       sts;

  // Configuration register access; the port never waits.
  assign pready  = 1'b1;
  assign win_sel = (paddr[gbnsw_pkg::AddrW-1:2] == gbnsw_pkg::AddrWindowSize[gbnsw_pkg::AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= gbnsw_pkg::WindowSizeRst;
    end else if (psel && penable && pwrite && pready && win_sel) begin
      window_size_q <= pwdata[gbnsw_pkg::WinW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (win_sel) begin
      prdata[gbnsw_pkg::WinW-1:0] = window_size_q;
    end
  end

  gbnsw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gbnsw_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .window_size_i (window_size_q),
    .in_data_i     (in_data_i),
    .out_data_o    (out_data_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

@@ sim/tb_go_back_n_sender_window_unit.sv @@
`timescale 1ns / 1ps

module tb_go_back_n_sender_window_unit;

  localparam int SeqSpace  = gbnsw_pkg::SeqSpace;
  localparam int SeqW      = gbnsw_pkg::SeqW;
  localparam int MaxWindow = gbnsw_pkg::MaxWindow;
  localparam int LenW      = gbnsw_pkg::LenW;
  localparam int WinW      = gbnsw_pkg::WinW;
  localparam int OpW       = gbnsw_pkg::OpW;
  localparam int KindW     = gbnsw_pkg::KindW;
  localparam int AddrW     = gbnsw_pkg::AddrW;
  localparam int DataW     = gbnsw_pkg::DataW;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  gbnsw_pkg::in_t     in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  gbnsw_pkg::out_t    out_data_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [AddrW-1:0]   paddr       = '0;
  logic [DataW-1:0]   pwdata      = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;

  go_back_n_sender_window_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Mirror of the sender window, updated at every accepted input transfer.
  logic [SeqW-1:0] base_seq   = '0;
  logic [SeqW-1:0] next_seq   = '0;
  logic [WinW-1:0] cfg_window = gbnsw_pkg::WindowSizeRst;
  logic [LenW-1:0] slot_len [SeqSpace];
  logic            end_flag   = 1'b0;

  gbnsw_pkg::out_t pending_results[$];
  int   fail_count  = 0;
  bit   in_gaps_on  = 1'b1;
  bit   out_stall_on = 1'b1;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog for a hung run.
  initial begin
    #5_000_000;
    $display("go_back_n_sender_window_unit regression: fail");
    $finish;
  end

  function automatic gbnsw_pkg::in_t make_item(logic [OpW-1:0] op, logic [SeqW-1:0] ack,
                                               logic [LenW-1:0] len);
    gbnsw_pkg::in_t item;
    item.opcode      = op;
    item.ack_number  = ack;
    item.data_length = len;
    return item;
  endfunction

  function automatic gbnsw_pkg::out_t make_result(logic [KindW-1:0] kind,
                                                  logic [SeqW-1:0] seq,
                                                  logic [LenW-1:0] len, logic restart,
                                                  logic done, logic fin);
    gbnsw_pkg::out_t r;
    r.kind          = kind;
    r.sequence_res  = seq;
    r.length        = len;
    r.restart_timer = restart;
    r.all_done      = done;
    r.last          = fin;
    return r;
  endfunction

  function automatic int outstanding_count();
    logic [SeqW-1:0] diff;
    diff = next_seq - base_seq;
    return int'(diff);
  endfunction

  // Effective window: zero acts as one, large values saturate.
  function automatic int window_limit();
    int w;
    w = int'(cfg_window);
    if (w < 1) w = 1;
    if (w > MaxWindow) w = MaxWindow;
    if (w > SeqSpace - 1) w = SeqSpace - 1;
    return w;
  endfunction

  // Mostly in-range lengths, with the odd value past 64.
  function automatic logic [LenW-1:0] pick_length();
    if ($urandom_range(0, 9) == 0) return LenW'($urandom_range(65, 127));
    return LenW'($urandom_range(0, 64));
  endfunction

  // Update the window mirror for one accepted item and queue its results.
  task automatic advance_window(gbnsw_pkg::in_t item);
    int              outs;
    logic [SeqW-1:0] off;
    logic [SeqW-1:0] seq;
    outs = outstanding_count();
    case (item.opcode)
      gbnsw_pkg::OpData: begin
        if (outs >= window_limit()) begin
          pending_results.push_back(make_result(gbnsw_pkg::KindFull, base_seq, '0,
                                                1'b0, 1'b0, 1'b1));
        end else begin
          slot_len[next_seq] = item.data_length;
          pending_results.push_back(make_result(gbnsw_pkg::KindSent, next_seq,
                                                item.data_length, outs == 0, 1'b0, 1'b1));
          next_seq = next_seq + 1'b1;
        end
      end
      gbnsw_pkg::OpAck: begin
        off = item.ack_number - base_seq;
        if (int'(off) < outs) begin
          base_seq = item.ack_number + 1'b1;
          pending_results.push_back(make_result(gbnsw_pkg::KindAckTaken, base_seq, '0,
                                                1'b1, end_flag && (base_seq == next_seq),
                                                1'b1));
        end else begin
          pending_results.push_back(make_result(gbnsw_pkg::KindAckIgn, base_seq, '0,
                                                1'b0, end_flag && (outs == 0), 1'b1));
        end
      end
      gbnsw_pkg::OpTimeout: begin
        if (outs == 0) begin
          pending_results.push_back(make_result(gbnsw_pkg::KindNone, base_seq, '0, 1'b0,
                                                end_flag, 1'b1));
        end else begin
          if (outs > MaxWindow) outs = MaxWindow;
          for (int i = 0; i < outs; i++) begin
            seq = base_seq + SeqW'(i);
            pending_results.push_back(make_result(gbnsw_pkg::KindResent, seq,
                                                  slot_len[seq], i == outs - 1, 1'b0,
                                                  i == outs - 1));
          end
        end
      end
      default: begin
        end_flag = 1'b1;
        pending_results.push_back(make_result(gbnsw_pkg::KindEnd, base_seq, '0, 1'b0,
                                              outs == 0, 1'b1));
      end
    endcase
  endtask

  // Present one item, hold it until the transfer, then maybe leave a gap.
  // Valid is left high after a zero gap so the next item follows directly.
  task automatic send_item(gbnsw_pkg::in_t item);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    advance_window(item);
    gap = in_gaps_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait until the block is idle, then write window_size over APB.
  task automatic write_window(logic [DataW-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= gbnsw_pkg::AddrWindowSize;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_window = value[WinW-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic report_failure(string what, gbnsw_pkg::out_t want, gbnsw_pkg::out_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s: expected kind=%0d seq=%0d len=%0d restart=%0b done=%0b last=%0b",
               what, want.kind, want.sequence_res, want.length, want.restart_timer,
               want.all_done, want.last);
      $display("  got kind=%0d seq=%0d len=%0d restart=%0b done=%0b last=%0b",
               got.kind, got.sequence_res, got.length, got.restart_timer,
               got.all_done, got.last);
    end
  endtask

  // Result side: check every transfer against the oldest expectation and
  // draw a stall for the receiver after each one.
  initial begin : result_checker
    gbnsw_pkg::out_t want;
    int   hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_valid_o && out_ready_i) begin
          if (pending_results.size() == 0) begin
            report_failure("unexpected result", 'x, out_data_o);
          end else begin
            want = pending_results.pop_front();
            if (out_data_o.kind !== want.kind ||
                out_data_o.sequence_res !== want.sequence_res ||
                out_data_o.length !== want.length ||
                out_data_o.restart_timer !== want.restart_timer ||
                out_data_o.all_done !== want.all_done ||
                out_data_o.last !== want.last) begin
              report_failure("result mismatch", want, out_data_o);
            end
          end
          hold = out_stall_on ? $urandom_range(0, 10) : 0;
          if (hold != 0) out_ready_i <= 1'b0;
        end else if (!out_ready_i) begin
          if (hold == 0) out_ready_i <= 1'b1;
          else hold--;
        end
      end
    end
  end

  // Timeout and acks with nothing outstanding.
  task automatic test_idle_window();
    send_item(make_item(gbnsw_pkg::OpTimeout, 5'd0, 7'd0));
    send_item(make_item(gbnsw_pkg::OpAck, 5'd5, 7'd0));
    send_item(make_item(gbnsw_pkg::OpAck, 5'd31, 7'd127));
  endtask

  // Sends with extreme lengths, an ack past the outstanding range, taken acks.
  task automatic test_send_and_ack();
    send_item(make_item(gbnsw_pkg::OpData, 5'd31, 7'd0));
    send_item(make_item(gbnsw_pkg::OpData, 5'd0, 7'd64));
    send_item(make_item(gbnsw_pkg::OpData, 5'd10, 7'd127));
    send_item(make_item(gbnsw_pkg::OpData, 5'd21, 7'd63));
    send_item(make_item(gbnsw_pkg::OpAck, 5'd20, 7'd0));
    send_item(make_item(gbnsw_pkg::OpAck, 5'd0, 7'd0));
    send_item(make_item(gbnsw_pkg::OpAck, 5'd1, 7'd0));
  endtask

  // Timeout walks every outstanding packet from the base on.
  task automatic test_timeout_resend();
    send_item(make_item(gbnsw_pkg::OpTimeout, 5'd0, 7'd0));
    send_item(make_item(gbnsw_pkg::OpAck, 5'd2, 7'd0));
  endtask

  // Window of zero acts as one; a small window refuses when full.
  task automatic test_window_limits();
    write_window(32'd0);
    send_item(make_item(gbnsw_pkg::OpData, 5'd0, 7'd9));
    send_item(make_item(gbnsw_pkg::OpAck, 5'd3, 7'd0));
    send_item(make_item(gbnsw_pkg::OpData, 5'd0, 7'd42));
    send_item(make_item(gbnsw_pkg::OpData, 5'd0, 7'd17));
    write_window(32'd2);
    send_item(make_item(gbnsw_pkg::OpData, 5'd0, 7'd1));
    send_item(make_item(gbnsw_pkg::OpData, 5'd0, 7'd2));
    send_item(make_item(gbnsw_pkg::OpTimeout, 5'd0, 7'd0));
  endtask

  // End of data with packets outstanding, then done once all are acked.
  task automatic test_end_of_data();
    send_item(make_item(gbnsw_pkg::OpEnd, 5'd0, 7'd0));
    send_item(make_item(gbnsw_pkg::OpAck, 5'd4, 7'd0));
    send_item(make_item(gbnsw_pkg::OpAck, 5'd5, 7'd0));
    send_item(make_item(gbnsw_pkg::OpTimeout, 5'd0, 7'd0));
    send_item(make_item(gbnsw_pkg::OpEnd, 5'd0, 7'd0));
    send_item(make_item(gbnsw_pkg::OpData, 5'd0, 7'd50));
  endtask

  // Random traffic, mostly well-formed: acks usually name an outstanding
  // sequence, the rest are arbitrary.
  task automatic run_traffic(int count, int data_pct);
    int              pick;
    int              outs;
    int              ack_cut;
    gbnsw_pkg::in_t  item;
    ack_cut = data_pct + (100 - data_pct) * 6 / 10;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      outs = outstanding_count();
      item = make_item(gbnsw_pkg::OpData, SeqW'($urandom), pick_length());
      if (pick >= data_pct && pick < ack_cut) begin
        item.opcode = gbnsw_pkg::OpAck;
        if (outs > 0 && $urandom_range(0, 3) != 0)
          item.ack_number = base_seq + SeqW'($urandom_range(0, outs - 1));
      end else if (pick >= ack_cut && pick < 97) begin
        item.opcode = gbnsw_pkg::OpTimeout;
      end else if (pick >= 97) begin
        item.opcode = gbnsw_pkg::OpEnd;
      end
      send_item(item);
    end
  endtask

  // Full and saturated windows, back to back and with idling.
  task automatic test_saturated_window();
    in_gaps_on   = 1'b1;
    out_stall_on = 1'b1;
    write_window(32'd16);
    run_traffic(40, 55);
    in_gaps_on   = 1'b0;
    out_stall_on = 1'b0;
    write_window(32'd31);
    run_traffic(40, 60);
  endtask

  // Windows lowered below the outstanding count.
  task automatic test_shrunk_window();
    in_gaps_on   = 1'b1;
    out_stall_on = 1'b1;
    write_window(32'd1);
    run_traffic(25, 45);
    write_window(32'd0);
    run_traffic(20, 45);
    out_stall_on = 1'b0;
    write_window(32'd3);
    run_traffic(30, 50);
  endtask

  // Random window sizes over the whole register range.
  task automatic test_random_traffic();
    in_gaps_on   = 1'b0;
    out_stall_on = 1'b1;
    write_window(32'($urandom_range(1, 31)));
    run_traffic(30, 55);
    in_gaps_on   = 1'b1;
    write_window(32'($urandom_range(0, 31)));
    run_traffic(35, 50);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_window();
    test_send_and_ack();
    test_timeout_resend();
    test_window_limits();
    test_end_of_data();
    test_saturated_window();
    test_shrunk_window();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("go_back_n_sender_window_unit regression: pass");
    end else begin
      $display("go_back_n_sender_window_unit regression: fail");
    end
    $finish;
  end

endmodule
